// ----- src/ppbs_pkg.sv -----
// Package for the palette packed block store.
// Holds the item structs, sizing constants and the sequencer state type.
// Depends on nothing.
package ppbs_pkg;

	localparam int SECTIONS     = 16;
	localparam int SEC_BITS     = 4;
	localparam int IDX_BITS     = 12;
	localparam int ID_BITS      = 13;
	localparam int PAL_BITS     = 8;
	localparam int CNT_BITS     = 9;
	localparam int WID_BITS     = 4;
	localparam logic [WID_BITS-1:0] START_BITS   = 4'd4;
	localparam logic [WID_BITS-1:0] PAL_MAX_BITS = 4'd8;
	localparam logic [WID_BITS-1:0] DIRECT_BITS  = 4'd13;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef struct packed {
		logic         req_type;
		logic [3:0]   col_x;
		logic [7:0]   height_y;
		logic [3:0]   row_z;
		logic [12:0]  block_id;
	} req_t;

	typedef struct packed {
		logic [12:0]  read_id;
		logic         section_present;
		logic [3:0]   entry_bits;
		logic [8:0]   palette_used;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_INIT,
		ST_SRCH,
		ST_SCMP,
		ST_FULL,
		ST_CV_RD,
		ST_CV_CHK,
		ST_CV_WR,
		ST_PUT,
		ST_RD,
		ST_RD_CHK,
		ST_RD_MAP,
		ST_DONE
	} state_t;

endpackage

// ----- src/palette_packed_block_store.sv -----
// Top level of the palette packed block store.
// Uses ppbs_pkg for the item structs, sizes and the sequencer states.
//
// Usage: the input channel (in_valid, in_ready, in_data) takes one request
// item, a read or a write of one block id at an x, y, z position. The
// output channel (out_valid, out_ready, out_data) returns one result item
// per request: the id at that position after the access, whether its
// section exists, the section's entry width and its palette fill.
// Entries are held one per word in an entry memory, so a width change
// inside palette mode changes no stored word; only the step to direct
// mode rewrites the section.
// Sequence: a read passes an entry read, a palette lookup and a map
// step before its result is loaded. A write into a present palette-mode
// section also searches the palette entry by entry. Creating a section
// clears its 4096 entries, one per cycle. Turning a section direct
// rewrites its 4096 entries by a read, a lookup and a write for each.
// Throughput: one item at a time; in_ready is high only when the
// sequencer is idle. A finished result waits in the output register, and
// the next item is accepted while it waits; only the next result stalls.
// Reset: all sections are absent. The memories are not cleared.
module palette_packed_block_store (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ppbs_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ppbs_pkg::rsp_t  out_data
);
	import ppbs_pkg::*;

	state_t state_q, state_nx;

	// Per-section control state, small enough for flip-flops.
	logic [SECTIONS-1:0]  valid_q;
	logic [WID_BITS-1:0]  width_q [SECTIONS];
	logic [CNT_BITS-1:0]  count_q [SECTIONS];

	// Latched request.
	logic [SEC_BITS-1:0]  sec_q;
	logic [IDX_BITS-1:0]  idx_q;
	logic [ID_BITS-1:0]   id_q;

	logic [IDX_BITS:0]    cnt_q;   // sweep or search counter
	logic [ID_BITS-1:0]   code_q;  // word to store at the addressed entry
	logic [ID_BITS-1:0]   raw_q;
	logic                 need_q;
	rsp_t                 res_q;
	rsp_t                 out_q;
	logic                 out_valid_q;

	// Memories.
	logic [ID_BITS-1:0] ent_mem [SECTIONS*4096];
	logic [ID_BITS-1:0] pal_mem [SECTIONS*256];
	logic [ID_BITS-1:0] ent_rd_q, pal_rd_q;

	logic                          ent_we, pal_we;
	logic [SEC_BITS+IDX_BITS-1:0]  ent_addr;
	logic [SEC_BITS+PAL_BITS-1:0]  pal_addr;
	logic [ID_BITS-1:0]            ent_wdata, pal_wdata;

	logic [WID_BITS-1:0]  cur_w;
	logic [CNT_BITS-1:0]  cur_n;
	logic                 cur_v;
	logic                 sweep_last;
	logic                 accept;
	logic                 pal_full;

	assign cur_w      = width_q[sec_q];
	assign cur_n      = count_q[sec_q];
	assign cur_v      = valid_q[sec_q];
	assign sweep_last = (cnt_q[IDX_BITS-1:0] == {IDX_BITS{1'b1}});
	assign accept     = in_valid && in_ready;
	assign pal_full   = (cur_n >= (CNT_BITS'(1) << cur_w));
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_data.req_type == REQ_WRITE) begin
						if (valid_q[in_data.height_y[7:4]]) begin
							if (width_q[in_data.height_y[7:4]] > PAL_MAX_BITS)
								state_nx = ST_PUT;
							else
								state_nx = ST_SRCH;
						end else if (in_data.block_id != '0) begin
							state_nx = ST_CLR;
						end else begin
							state_nx = ST_RD;
						end
					end else begin
						state_nx = ST_RD;
					end
				end
			end
			ST_CLR:    if (sweep_last) state_nx = ST_INIT;
			ST_INIT:   state_nx = ST_SRCH;
			ST_SRCH:   state_nx = ST_SCMP;
			ST_SCMP: begin
				if (pal_rd_q == id_q)
					state_nx = ST_PUT;
				else if (cnt_q[CNT_BITS-1:0] + 1'b1 == cur_n)
					state_nx = ST_FULL;
				else
					state_nx = ST_SRCH;
			end
			ST_FULL: begin
				if (pal_full && cur_w >= PAL_MAX_BITS)
					state_nx = ST_CV_RD;
				else
					state_nx = ST_PUT;
			end
			ST_CV_RD:  state_nx = ST_CV_CHK;
			ST_CV_CHK: state_nx = ST_CV_WR;
			ST_CV_WR:  state_nx = sweep_last ? ST_PUT : ST_CV_RD;
			ST_PUT:    state_nx = ST_RD;
			ST_RD:     state_nx = ST_RD_CHK;
			ST_RD_CHK: state_nx = ST_RD_MAP;
			ST_RD_MAP: state_nx = ST_DONE;
			ST_DONE:   if (!out_valid_q || out_ready) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// Memory port controls.
	always_comb begin
		ent_we    = 1'b0;
		ent_addr  = {sec_q, idx_q};
		ent_wdata = code_q;
		pal_we    = 1'b0;
		pal_addr  = {sec_q, cnt_q[PAL_BITS-1:0]};
		pal_wdata = id_q;
		case (state_q)
			ST_CLR: begin
				ent_we    = 1'b1;
				ent_addr  = {sec_q, cnt_q[IDX_BITS-1:0]};
				ent_wdata = '0;
			end
			ST_INIT: begin
				pal_we    = 1'b1;
				pal_addr  = {sec_q, {PAL_BITS{1'b0}}};
				pal_wdata = '0;
			end
			ST_FULL: begin
				pal_we   = !(pal_full && cur_w >= PAL_MAX_BITS);
				pal_addr = {sec_q, cur_n[PAL_BITS-1:0]};
			end
			ST_CV_RD:  ent_addr = {sec_q, cnt_q[IDX_BITS-1:0]};
			ST_CV_CHK: pal_addr = {sec_q, ent_rd_q[PAL_BITS-1:0]};
			ST_CV_WR: begin
				ent_we    = 1'b1;
				ent_addr  = {sec_q, cnt_q[IDX_BITS-1:0]};
				ent_wdata = need_q ? pal_rd_q : raw_q;
			end
			ST_PUT:    ent_we = 1'b1;
			ST_RD_CHK: pal_addr = {sec_q, ent_rd_q[PAL_BITS-1:0]};
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ent_we)
			ent_mem[ent_addr] <= ent_wdata;
		ent_rd_q <= ent_mem[ent_addr];
	end

	always_ff @(posedge clk) begin
		if (pal_we)
			pal_mem[pal_addr] <= pal_wdata;
		pal_rd_q <= pal_mem[pal_addr];
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sec_q  <= in_data.height_y[7:4];
				idx_q  <= {in_data.height_y[3:0], in_data.row_z, in_data.col_x};
				id_q   <= in_data.block_id;
				code_q <= in_data.block_id;
				cnt_q  <= '0;
			end
			ST_CLR:  cnt_q <= cnt_q + 1'b1;
			ST_INIT: cnt_q <= '0;
			ST_SCMP: begin
				code_q <= ID_BITS'(cnt_q);
				cnt_q  <= cnt_q + 1'b1;
			end
			ST_FULL: begin
				code_q <= ID_BITS'(cur_n);
				cnt_q  <= '0;
			end
			ST_CV_CHK: begin
				raw_q  <= ent_rd_q;
				need_q <= (ent_rd_q < ID_BITS'(cur_n));
			end
			ST_CV_WR: begin
				cnt_q  <= cnt_q + 1'b1;
				code_q <= id_q;
			end
			ST_RD_CHK: begin
				raw_q  <= ent_rd_q;
				need_q <= (cur_w <= PAL_MAX_BITS) && (ent_rd_q < ID_BITS'(cur_n));
			end
			ST_RD_MAP: begin
				res_q.section_present <= cur_v;
				res_q.read_id      <= cur_v ? (need_q ? pal_rd_q : raw_q) : '0;
				res_q.entry_bits   <= cur_v ? cur_w : '0;
				res_q.palette_used <= cur_v ? cur_n : '0;
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && (!out_valid_q || out_ready))
			out_q <= res_q;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
			for (int i = 0; i < SECTIONS; i++) begin
				width_q[i] <= '0;
				count_q[i] <= '0;
			end
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DONE && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					valid_q[sec_q] <= 1'b1;
					width_q[sec_q] <= START_BITS;
					count_q[sec_q] <= CNT_BITS'(1);
				end
				ST_FULL: begin
					if (!(pal_full && cur_w >= PAL_MAX_BITS)) begin
						count_q[sec_q] <= cur_n + 1'b1;
						if (pal_full)
							width_q[sec_q] <= cur_w + 1'b1;
					end
				end
				ST_CV_WR: if (sweep_last) width_q[sec_q] <= DIRECT_BITS;
				default: begin
				end
			endcase
		end
	end

	// A write request never leaves the block with its section absent
	// unless the id was zero.
	a_write_creates: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT) |-> cur_v)
		else $error("entry write into an absent section");

	a_present_width: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_MAP && cur_v) |-> (cur_w >= START_BITS && cur_n != '0))
		else $error("present section with bad width or empty palette");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result changed while stalled");

	a_one_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !out_ready) |=> (state_q == ST_DONE))
		else $error("result dropped while output was full");

endmodule
